/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset
`define FPA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* hdl/fpa_pkg.sv */
// Shared types, command codes and saturation helper for the Q24.8 ALU
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_GT  = 4'd4,
    CMD_LT  = 4'd5,
    CMD_GE  = 4'd6,
    CMD_LE  = 4'd7,
    CMD_EQ  = 4'd8,
    CMD_NE  = 4'd9,
    CMD_INT = 4'd10
  } fpa_cmd_e;

  // What the back end still has to do with a request
  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } fpa_kind_e;

  typedef struct packed {
    logic [31:0] val;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } fpa_result_t;

  typedef struct packed {
    fpa_kind_e   kind;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    fpa_result_t res;
  } fpa_item_t;

  localparam logic [63:0] PosLimit = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h0000_0000_8000_0000;

  // Sign and magnitude to saturated 32-bit value, overflow in the top bit
  function automatic logic [32:0] fpa_sat(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] m;
    logic [31:0] v;
    logic        o;
    lim = neg ? NegLimit : PosLimit;
    o   = (mag > lim);
    m   = o ? lim : mag;
    v   = neg ? (32'd0 - m[31:0]) : m[31:0];
    return {o, v};
  endfunction

endpackage

/* hdl/fpa_queue.sv */
// Small register queue between the front and back ends
module fpa_queue import fpa_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (AW+1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end
endmodule

/* hdl/fpa_front.sv */
// Front end: accepts requests, finishes every command except multiply and nonzero divide, classifies the rest
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output fpa_item_t   item_o
);
  logic        v_q;
  fpa_item_t   item_q, item_d;
  logic [31:0] mag_a, mag_b, ip_mag;
  logic [32:0] sum, dif, isat;
  logic        lt, eq;

  assign in_ready_o   = !v_q || item_ready_i;
  assign item_valid_o = v_q;
  assign item_o       = item_q;

  // Operand preparation
  always_comb begin
    mag_a  = operand_a_i[31] ? (32'd0 - operand_a_i) : operand_a_i;
    mag_b  = operand_b_i[31] ? (32'd0 - operand_b_i) : operand_b_i;
    sum    = {operand_a_i[31], operand_a_i} + {operand_b_i[31], operand_b_i};
    dif    = {operand_a_i[31], operand_a_i} - {operand_b_i[31], operand_b_i};
    lt     = ($signed(operand_a_i) < $signed(operand_b_i));
    eq     = (operand_a_i == operand_b_i);
    ip_mag = mag_a >> FRAC_BITS;
    isat   = fpa_sat(operand_a_i[31], {32'd0, ip_mag});
  end

  // Classification
  always_comb begin
    item_d       = '0;
    item_d.kind  = KIND_DONE;
    item_d.mag_a = mag_a;
    item_d.mag_b = mag_b;
    item_d.neg   = operand_a_i[31] ^ operand_b_i[31];
    unique case (fpa_cmd_e'(cmd_i))
      CMD_ADD: begin
        item_d.res.ovf = sum[32] ^ sum[31];
        item_d.res.val = item_d.res.ovf ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : sum[31:0];
      end
      CMD_SUB: begin
        item_d.res.ovf = dif[32] ^ dif[31];
        item_d.res.val = item_d.res.ovf ? (dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : dif[31:0];
      end
      CMD_MUL: item_d.kind = KIND_MUL;
      CMD_DIV: begin
        if (operand_b_i == '0) item_d.res.dz = 1'b1;
        else                   item_d.kind   = KIND_DIV;
      end
      CMD_GT:  item_d.res.cmp = !lt && !eq;
      CMD_LT:  item_d.res.cmp = lt;
      CMD_GE:  item_d.res.cmp = !lt;
      CMD_LE:  item_d.res.cmp = lt || eq;
      CMD_EQ:  item_d.res.cmp = eq;
      CMD_NE:  item_d.res.cmp = !eq;
      CMD_INT: begin
        item_d.res.val = isat[31:0];
        item_d.res.ovf = isat[32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (in_ready_o) v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= item_d;
  end
endmodule

/* hdl/fpa_back.sv */
// Back end: pipelined multiplier and one-bit-per-stage divider with rounding
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  fpa_item_t   item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fpa_result_t out_o
);
  localparam int NW = 32 + FRAC_BITS;

  typedef struct packed {
    fpa_kind_e   kind;
    logic        neg;
    logic [31:0] d;
    logic [NW-1:0] n;
    logic [31:0] rem;
    logic [NW-1:0] q;
    logic [63:0] prod;
    fpa_result_t res;
  } fpa_stage_t;

  fpa_stage_t  pipe_q [NW+1];
  fpa_stage_t  step_d [NW];
  logic        v_q    [NW+1];
  logic        adv;
  logic        out_v_q;
  fpa_result_t out_q, fin_d;

  // Whole pipeline moves when the output register can take a result
  assign adv          = !out_v_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = out_v_q;
  assign out_o        = out_q;

  // One restoring division step per stage
  function automatic fpa_stage_t div_step(input fpa_stage_t s);
    fpa_stage_t r;
    logic [32:0] t;
    r = s;
    t = {s.rem, s.n[NW-1]};
    r.n = {s.n[NW-2:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      r.rem = 32'(t - {1'b0, s.d});
      r.q   = {s.q[NW-2:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.q   = {s.q[NW-2:0], 1'b0};
    end
    return r;
  endfunction

  for (genvar i = 0; i < NW; i++) begin : g_div
    always_comb step_d[i] = div_step(pipe_q[i]);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NW; i++) v_q[i] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= item_valid_i;
      for (int i = 0; i < NW; i++) v_q[i+1] <= v_q[i];
      out_v_q <= v_q[NW];
    end
  end

  // Stage payloads: entry stage holds the product and the divider set-up
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q[0].kind <= item_i.kind;
      pipe_q[0].neg  <= item_i.neg;
      pipe_q[0].d    <= item_i.mag_b;
      pipe_q[0].n    <= {item_i.mag_a, FRAC_BITS'(0)};
      pipe_q[0].rem  <= '0;
      pipe_q[0].q    <= '0;
      pipe_q[0].prod <= item_i.mag_a * item_i.mag_b;
      pipe_q[0].res  <= item_i.res;
      for (int i = 0; i < NW; i++) pipe_q[i+1] <= step_d[i];
      out_q <= fin_d;
    end
  end

  // Rounding and saturation
  always_comb begin
    logic [63:0] mm, qq;
    logic [32:0] sat;
    mm = (pipe_q[NW].prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    qq = 64'(pipe_q[NW].q) + 64'({pipe_q[NW].rem, 1'b0} >= {1'b0, pipe_q[NW].d});
    fin_d = pipe_q[NW].res;
    sat   = '0;
    unique case (pipe_q[NW].kind)
      KIND_MUL: sat = fpa_sat(pipe_q[NW].neg, mm);
      KIND_DIV: sat = fpa_sat(pipe_q[NW].neg, qq);
      default:  ;
    endcase
    if (pipe_q[NW].kind != KIND_DONE) begin
      fin_d.val = sat[31:0];
      fin_d.ovf = sat[32];
    end
  end
endmodule

/* hdl/fixed_point_q24_8_alu.sv */
// Top level of the Q24.8 fixed-point arithmetic and compare unit
// Takes one request per clock and delivers one result per clock while the output is not stalled.
// Every request, whatever its command, follows the same path: a front register, a two-entry
// queue, a product/set-up stage, 32 + FRAC_BITS divider stages that retire one quotient bit
// each, and the output register. The front register loads at the accepting edge. Results
// come out in request order. Multiply and divide round to nearest with halves away from zero;
// out-of-range results saturate and set overflow_flag_o; division by zero returns 0 with
// divide_by_zero_o set.
`include "assert_macros.svh"
module fixed_point_q24_8_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic        compare_true_o,
  output logic        overflow_flag_o,
  output logic        divide_by_zero_o
);
  fpa_item_t   f_item, b_item;
  logic        f_valid, f_ready, b_valid, b_ready;
  fpa_result_t res;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .cmd_i,
    .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .item_valid_o(f_valid), .item_ready_i(f_ready), .item_o(f_item)
  );

  fpa_queue #(.Width($bits(fpa_item_t)), .Depth(2)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_item),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_item)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i(b_valid), .item_ready_o(b_ready), .item_i(b_item),
    .out_valid_o, .out_ready_i, .out_o(res)
  );

  assign result_value_o   = res.val;
  assign compare_true_o   = res.cmp;
  assign overflow_flag_o  = res.ovf;
  assign divide_by_zero_o = res.dz;

  `FPA_ASSERT(a_dz_zero, clk_i, rst_ni,
    (out_valid_o && divide_by_zero_o) |-> (result_value_o == '0 && !overflow_flag_o),
    "divide by zero result not clean")
  `FPA_ASSERT_NEVER(a_cmp_excl, clk_i, rst_ni,
    out_valid_o && compare_true_o && (overflow_flag_o || divide_by_zero_o),
    "compare result carries arithmetic flags")
  `FPA_ASSERT(a_cmp_val, clk_i, rst_ni,
    (out_valid_o && compare_true_o) |-> (result_value_o == '0),
    "compare result value not zero")
endmodule

/* dv/fixed_point_q24_8_alu_tb.sv */
// Self-checking testbench for the Q24.8 fixed-point arithmetic and compare unit
module fixed_point_q24_8_alu_tb import fpa_pkg::*; ();

  localparam int FracBits   = 8;
  localparam int Latency    = FracBits + 35;
  localparam int StallLimit = 20000;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct {
    logic [31:0] val;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  cmd_i;
  logic signed [31:0] operand_a_i;
  logic signed [31:0] operand_b_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [31:0] result_value_o;
  logic        compare_true_o;
  logic        overflow_flag_o;
  logic        divide_by_zero_o;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       errors;
  int       idle_cycles;
  int       send_idle_pct;
  int       recv_stall_pct;
  logic     in_acc;

  fixed_point_q24_8_alu #(.FRAC_BITS(FracBits)) dut (.*);

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Saturate a sign and magnitude to 32 bits
  function automatic alu_res_t saturate(input logic neg, input logic [63:0] mag);
    alu_res_t r;
    r = '{default: '0};
    if (neg && mag > 64'h8000_0000) begin
      r.ovf = 1'b1;
      mag   = 64'h8000_0000;
    end else if (!neg && mag > 64'h7FFF_FFFF) begin
      r.ovf = 1'b1;
      mag   = 64'h7FFF_FFFF;
    end
    r.val = neg ? 32'd0 - mag[31:0] : mag[31:0];
    return r;
  endfunction

  // Exact integer arithmetic on the operands
  function automatic alu_res_t alu_compute(input alu_req_t q);
    alu_res_t    r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] p;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    r  = '{default: '0};
    a  = {{32{q.a[31]}}, q.a};
    b  = {{32{q.b[31]}}, q.b};
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    case (q.cmd)
      CMD_ADD: r = saturate(a + b < 0, (a + b < 0) ? -(a + b) : a + b);
      CMD_SUB: r = saturate(a - b < 0, (a - b < 0) ? -(a - b) : a - b);
      CMD_MUL: begin
        p = a * b;
        m = ((p < 0 ? -p : p) + (64'd1 << (FracBits - 1))) >> FracBits;
        r = saturate(p < 0, m);
      end
      CMD_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else r = saturate((a < 0) != (b < 0), (2 * (ma << FracBits) + mb) / (2 * mb));
      end
      CMD_GT: r.cmp = a > b;
      CMD_LT: r.cmp = a < b;
      CMD_GE: r.cmp = a >= b;
      CMD_LE: r.cmp = a <= b;
      CMD_EQ: r.cmp = a == b;
      CMD_NE: r.cmp = a != b;
      CMD_INT: r = saturate(a < 0, ma >> FracBits);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return $urandom_range(0, 1) ? $urandom_range(0, 1024) : -$urandom_range(0, 1024);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(input logic [3:0] c, input logic [31:0] a, input logic [31:0] b);
    alu_req_t q;
    q.cmd = c;
    q.a   = a;
    q.b   = b;
    pending_reqs.push_back(q);
  endtask

  // Request acceptance as seen at the rising edge
  always @(posedge clk_i) in_acc <= in_valid_i && in_ready_o;

  // Driver: present a request at the falling edge, hold it until accepted
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() != 0 &&
          ((in_valid_i && !in_acc) || $urandom_range(1, 100) > send_idle_pct)) begin
        in_valid_i  <= 1'b1;
        cmd_i       <= pending_reqs[0].cmd;
        operand_a_i <= pending_reqs[0].a;
        operand_b_i <= pending_reqs[0].b;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= $urandom_range(1, 100) > recv_stall_pct;
    end
  end

  // Monitor: predict on acceptance, check results in order
  always @(posedge clk_i) begin
    alu_req_t q;
    alu_res_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        q.cmd = cmd_i;
        q.a   = operand_a_i;
        q.b   = operand_b_i;
        expected_results.push_back(alu_compute(q));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", result_value_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result_value_o !== e.val) begin
            $error("result_value expected %h actual %h", e.val, result_value_o);
            errors++;
          end
          if (compare_true_o !== e.cmp) begin
            $error("compare_true expected %b actual %b", e.cmp, compare_true_o);
            errors++;
          end
          if (overflow_flag_o !== e.ovf) begin
            $error("overflow_flag expected %b actual %b", e.ovf, overflow_flag_o);
            errors++;
          end
          if (divide_by_zero_o !== e.dz) begin
            $error("divide_by_zero expected %b actual %b", e.dz, divide_by_zero_o);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("fixed_point_q24_8_alu: mismatch");
      $finish;
    end
  end

  // Stimulus and phase sequencing
  initial begin
    logic [3:0] c;
    errors         = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_ready_i    = 1'b0;
    cmd_i          = '0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every command, unused codes, rounding halves
    queue_req(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_req(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    queue_req(CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_req(CMD_MUL, 32'h0000_0180, 32'hFFFF_FF01);
    queue_req(CMD_MUL, 32'h0000_0001, 32'h0000_0080);
    queue_req(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
    queue_req(CMD_DIV, 32'h0000_0100, 32'h0000_0000);
    queue_req(CMD_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    queue_req(CMD_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_req(CMD_DIV, 32'h0000_0001, 32'h0000_0200);
    queue_req(CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
    for (int i = CMD_GT; i <= CMD_NE; i++) begin
      queue_req(4'(i), 32'h0000_0005, 32'h0000_0005);
      queue_req(4'(i), 32'h8000_0000, 32'h7FFF_FFFF);
    end
    queue_req(CMD_INT, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(CMD_INT, 32'hFFFF_FE80, 32'h0);
    queue_req(4'd11, 32'h1, 32'h1);
    queue_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random requests over four phases of input idling and output stalling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 21) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 84 : 21) : 0;
      for (int i = 0; i < 150; i++) begin
        c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                         : 4'($urandom_range(0, 10));
        queue_req(c, rand_operand(), rand_operand());
      end
      while (pending_reqs.size() != 0 || expected_results.size() != 0)
        @(posedge clk_i);
    end

    repeat (Latency * 2) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("fixed_point_q24_8_alu: match");
    end else begin
      $display("fixed_point_q24_8_alu: mismatch");
    end
    $finish;
  end

endmodule
